// File: design/itd_pkg.sv
// Package for the indexed texel decoder.
// Holds codes, configuration and item structs and the color helpers.
// No dependencies.
package itd_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int FIFO_DEPTH          = 4;
  localparam int FIFO_LEVEL_W        = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 3;

  localparam logic       CMD_PAL_WRITE = 1'b0;
  localparam logic       CMD_PIXEL     = 1'b1;
  localparam logic [2:0] FMT_RGBA32    = 3'd3;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_IDX8   = 2'd1,
    MODE_IDX4   = 2'd2,
    MODE_NONE   = 2'd3
  } pix_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_MODE = 2'd0,
    REG_PAL_LINEAR = 2'd1,
    REG_PAL_PADDED = 2'd2,
    REG_PAL_FORMAT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    pix_mode_t   pixel_mode;
    logic        palette_linear;
    logic        palette_padded;
    logic [2:0]  palette_format;
  } cfg_t;

  // one palette access or one direct pixel
  typedef struct packed {
    logic        we;
    logic        rd;
    logic [7:0]  addr;
    logic [31:0] data;
    logic        direct;
    logic        err;
    logic        last;
  } op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       format_error;
    logic       last_of_run;
  } pix_t;

  function automatic logic [7:0] swap_bits_3_4(input logic [7:0] i);
    return {i[7:5], i[3], i[4], i[2:0]};
  endfunction

  function automatic logic [7:0] double_alpha(input logic [7:0] a);
    return a[7] ? 8'hFF : {a[6:0], 1'b0};
  endfunction

endpackage

// File: design/itd_in_if.sv
// Input channel of the indexed texel decoder: palette writes and pixel items.
// Standalone, no package needed.
interface itd_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  palette_slot;
  logic [31:0] data_word;
  logic        low_nibble_only;

  modport source (output valid, cmd, palette_slot, data_word, low_nibble_only,
                  input ready);
  modport sink   (input valid, cmd, palette_slot, data_word, low_nibble_only,
                  output ready);
endinterface

// File: design/itd_out_if.sv
// Output channel of the indexed texel decoder: one RGBA8 pixel per item.
// Standalone, no package needed.
interface itd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       format_error;
  logic       last_of_run;

  modport source (output valid, red, green, blue, alpha, format_error, last_of_run,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, format_error, last_of_run,
                  output ready);
endinterface

// File: design/itd_cfg_if.sv
// Configuration write channel of the indexed texel decoder.
// Uses itd_pkg for index and data widths.
interface itd_cfg_if;
  import itd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/itd_palette_ram.sv
// Palette store: synchronous memory, one write and one read port,
// read data registered. Uses itd_pkg.
module itd_palette_ram import itd_pkg::*; #(
  parameter int DEPTH = PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [31:0] wdata,
  input  logic        re,
  input  logic [7:0]  raddr,
  output logic [31:0] rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] q;
  logic        oor;

  always_ff @(posedge clk) begin
    if (we && ({1'b0, waddr} < 9'(DEPTH))) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      oor <= ({1'b0, raddr} >= 9'(DEPTH));
      q   <= mem[raddr[AW-1:0]];
    end
  end

  assign rdata = oor ? 32'h0 : q;
endmodule

// File: design/itd_issue.sv
// Issue stage: holds one input item and issues its palette write, direct
// pixel or one to two lookups, one per cycle while credit_ok. Uses itd_pkg.
module itd_issue import itd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  itd_in_if.sink     in_ch,
  input  cfg_t       cfg,
  input  logic       credit_ok,
  output logic       op_valid,
  output op_t        op
);
  logic        hold_valid;
  logic        hold_cmd;
  logic [7:0]  hold_slot;
  logic [31:0] hold_word;
  logic        hold_low;
  logic        phase;

  logic        last_op;
  logic        fmt_err;
  logic [3:0]  nib;
  logic        fire;
  logic        done;
  logic        accept;

  always_comb begin
    op      = '0;
    last_op = 1'b1;
    fmt_err = (cfg.palette_format != FMT_RGBA32);
    nib     = phase ? hold_word[7:4] : hold_word[3:0];
    if (hold_cmd == CMD_PAL_WRITE) begin
      op.we   = 1'b1;
      op.addr = hold_slot;
      op.data = hold_word;
    end else begin
      case (cfg.pixel_mode)
        MODE_DIRECT: begin
          op.rd     = 1'b1;
          op.direct = 1'b1;
          op.data   = hold_word;
        end
        MODE_IDX8: begin
          op.rd   = 1'b1;
          op.err  = fmt_err;
          op.addr = cfg.palette_linear ? hold_word[7:0] : swap_bits_3_4(hold_word[7:0]);
        end
        MODE_IDX4: begin
          op.rd   = 1'b1;
          op.err  = fmt_err;
          op.addr = (!cfg.palette_linear && cfg.palette_padded) ?
                    swap_bits_3_4({4'h0, nib}) : {4'h0, nib};
          last_op = hold_low || phase;
        end
        default: begin
          op.rd = 1'b0;
        end
      endcase
    end
    op.last = last_op;
  end

  assign fire         = hold_valid && (!op.rd || credit_ok);
  assign done         = fire && last_op;
  assign op_valid     = fire;
  assign in_ch.ready  = !hold_valid || done;
  assign accept       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (done) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (fire) begin
      phase      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd  <= in_ch.cmd;
      hold_slot <= in_ch.palette_slot;
      hold_word <= in_ch.data_word;
      hold_low  <= in_ch.low_nibble_only;
    end
  end
endmodule

// File: design/itd_format.sv
// Pixel forming stage: pairs palette read data with the issued sideband
// and builds the RGBA8 result. Uses itd_pkg.
module itd_format import itd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  input  op_t         op,
  input  logic [31:0] ram_q,
  output logic        push_valid,
  output pix_t        push
);
  logic        s1_valid;
  logic        s1_direct;
  logic        s1_err;
  logic        s1_last;
  logic [31:0] s1_word;
  logic [31:0] color;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= op_valid && op.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op.rd) begin
      s1_direct <= op.direct;
      s1_err    <= op.err;
      s1_last   <= op.last;
      s1_word   <= op.data;
    end
  end

  always_comb begin
    color             = s1_err ? 32'h0 : (s1_direct ? s1_word : ram_q);
    push.red          = color[7:0];
    push.green        = color[15:8];
    push.blue         = color[23:16];
    push.alpha        = double_alpha(color[31:24]);
    push.format_error = s1_err;
    push.last_of_run  = s1_last;
  end

  assign push_valid = s1_valid;
endmodule

// File: design/itd_out_fifo.sv
// Output queue: small register FIFO that parts the pixel pipeline from
// the output channel. Uses itd_pkg.
module itd_out_fifo import itd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  input  pix_t                    push,
  itd_out_if.source               out_ch,
  output logic [FIFO_LEVEL_W-1:0] level
);
  localparam int PW = $clog2(FIFO_DEPTH);

  pix_t          buf_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          pop;
  pix_t          head;

  assign head                = buf_q[rd_ptr];
  assign out_ch.valid        = (level != '0);
  assign out_ch.red          = head.red;
  assign out_ch.green        = head.green;
  assign out_ch.blue         = head.blue;
  assign out_ch.alpha        = head.alpha;
  assign out_ch.format_error = head.format_error;
  assign out_ch.last_of_run  = head.last_of_run;
  assign pop                 = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + FIFO_LEVEL_W'(push_valid) - FIFO_LEVEL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      buf_q[wr_ptr] <= push;
    end
  end
endmodule

// File: design/indexed_texel_decoder_top.sv
// Indexed texel decoder: pixels pass the issue hold, forming register and
// output queue. One item per cycle for writes, direct and 8-bit pixels if
// the queue has room; a two-pixel 4-bit item issues two lookups in turn on
// the single palette read port. Synchronous reset clears control and loads
// register defaults; palette store not cleared: reads valid only if written.
module indexed_texel_decoder_top import itd_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  itd_in_if.sink    in_ch,
  itd_out_if.source out_ch,
  itd_cfg_if.sink   cfg
);
  cfg_t                    cfg_q;
  logic                    op_valid;
  op_t                     op;
  logic [31:0]             ram_q;
  logic                    push_valid;
  pix_t                    push;
  logic [FIFO_LEVEL_W-1:0] level;
  logic                    credit_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.pixel_mode     <= MODE_IDX8;
      cfg_q.palette_linear <= 1'b0;
      cfg_q.palette_padded <= 1'b1;
      cfg_q.palette_format <= FMT_RGBA32;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_PIXEL_MODE: cfg_q.pixel_mode     <= pix_mode_t'(cfg.data[1:0]);
        REG_PAL_LINEAR: cfg_q.palette_linear <= cfg.data[0];
        REG_PAL_PADDED: cfg_q.palette_padded <= cfg.data[0];
        REG_PAL_FORMAT: cfg_q.palette_format <= cfg.data[2:0];
        default:        cfg_q                <= cfg_q;
      endcase
    end
  end

  assign credit_ok = ({1'b0, level} + (FIFO_LEVEL_W+1)'(push_valid))
                     < (FIFO_LEVEL_W+1)'(FIFO_DEPTH);

  itd_issue u_issue (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg_q),
    .credit_ok (credit_ok),
    .op_valid  (op_valid),
    .op        (op)
  );

  itd_palette_ram #(
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (op_valid && op.we),
    .waddr (op.addr),
    .wdata (op.data),
    .re    (op_valid && op.rd && !op.direct && !op.err),
    .raddr (op.addr),
    .rdata (ram_q)
  );

  itd_format u_format (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .op         (op),
    .ram_q      (ram_q),
    .push_valid (push_valid),
    .push       (push)
  );

  itd_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push       (push),
    .out_ch     (out_ch),
    .level      (level)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> ({1'b0, level} < (FIFO_LEVEL_W+1)'(FIFO_DEPTH)))
    else $error("output queue overflow");

  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    push_valid |=> (level != '0))
    else $error("pushed pixel not held in output queue");

  a_lookup_follows_issue: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op.rd) |=> push_valid)
    else $error("issued pixel did not reach the forming stage");
endmodule
